FILE: rtl/multi_mode_key_debouncer_unit_macros.svh
// Assertion macros shared by the debouncer RTL.
// They sample on clk and are disabled while rst_n is low.
`ifndef MULTI_MODE_KEY_DEBOUNCER_UNIT_MACROS_SVH
`define MULTI_MODE_KEY_DEBOUNCER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMKD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMKD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mmkd_pkg.sv
`timescale 1ns / 1ps
package mmkd_pkg;

    localparam int KEY_COUNT_DEF  = 16;
    localparam int HIST_DEPTH_DEF = 8;

    localparam int KEY_W      = 4;
    localparam int TIME_W     = 32;
    localparam int WAIT_W     = 16;
    localparam int SCNT_W     = 16;
    localparam int SCFG_W     = 5;
    // Ring pointer and fill are sized for the deepest ring the block supports.
    localparam int PTR_W      = 5;
    localparam int FILL_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MIN_FILL   = 4;

    typedef enum logic [1:0] {
        M_DELAY = 2'd0,
        M_INTEG = 2'd1,
        M_LOCK  = 2'd2,
        M_ADAPT = 2'd3
    } method_t;

    localparam logic [CFG_IDX_W-1:0] REG_METHOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIST    = 3'd5;

    typedef struct packed {
        method_t             method;
        logic [WAIT_W-1:0]   delay_ms;
        logic [SCFG_W-1:0]   sample_count;
        logic [WAIT_W-1:0]   adaptive_min_ms;
        logic [WAIT_W-1:0]   adaptive_max_ms;
        logic                history_enable;
    } cfg_t;

    typedef struct packed {
        logic                debounced;
        logic                last_raw;
        logic [TIME_W-1:0]   last_change;
        logic [TIME_W-1:0]   lock_until;
        logic [SCNT_W-1:0]   sample_cnt;
        logic [TIME_W-1:0]   change_cnt;
        logic [TIME_W-1:0]   longest;
        logic [PTR_W-1:0]    wptr;
        logic [FILL_W-1:0]   fill;
    } key_state_t;

endpackage

FILE: rtl/mmkd_if.sv
`timescale 1ns / 1ps
interface mmkd_in_if import mmkd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  key_index;
    logic              raw_level;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, key_index, raw_level, time_ms, input ready);
    modport sink (input valid, key_index, raw_level, time_ms, output ready);
endinterface

interface mmkd_out_if import mmkd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              confirmed_change;
    logic              stable_level;
    logic              pressed_edge;
    logic              released_edge;
    logic              bounce_filtered;
    logic [TIME_W-1:0] raw_change_count;
    logic [TIME_W-1:0] max_bounce_ms;
    logic [WAIT_W-1:0] wait_used_ms;

    modport source (output valid, confirmed_change, stable_level, pressed_edge,
                    released_edge, bounce_filtered, raw_change_count, max_bounce_ms,
                    wait_used_ms, input ready);
    modport sink (input valid, confirmed_change, stable_level, pressed_edge,
                  released_edge, bounce_filtered, raw_change_count, max_bounce_ms,
                  wait_used_ms, output ready);
endinterface

FILE: rtl/multi_mode_key_debouncer_unit.sv
// Multi-mode key debouncer, one state record per key in a synchronous RAM.
// sample_in carries one item per key sample (key_index, raw_level, time_ms);
// result_out returns exactly one item per sample, in order.
// The configuration port writes register cfg_index at any edge with cfg_we high;
// write it only while no sample is in flight.
// One item is in work at a time. From acceptance until its result is loaded,
// an item goes through read of the key record, update, decision, write-back.
// In adaptive mode with 4 or more logged stamps the history ring of the key is
// read one entry per cycle, between the update and the decision steps.
// A key index at or above KEY_COUNT skips to write-back with an all-zero result.
// The result sits in an output register, so the next sample is accepted while
// it waits; if the receiver stalls, the following item holds in write-back.
// Reset clears the configuration to its defaults and the per-key valid bits, so
// every key record reads as zero until first written; the history ring needs no
// clearing because only entries counted by the fill field are ever read.
`timescale 1ns / 1ps
`include "multi_mode_key_debouncer_unit_macros.svh"
module multi_mode_key_debouncer_unit import mmkd_pkg::*; #(
    parameter int KEY_COUNT     = KEY_COUNT_DEF,
    parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    mmkd_in_if.sink               sample_in,
    mmkd_out_if.source            result_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int KA_W         = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int KX_W         = (KA_W > KEY_W) ? KA_W : KEY_W;
    localparam int HIST_ENTRIES = KEY_COUNT * HISTORY_DEPTH;
    localparam int HA_W         = $clog2(HIST_ENTRIES);
    localparam int KS_W         = $bits(key_state_t);
    localparam int POS_W        = PTR_W + 2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UPD  = 5'b00010,
        S_SCAN = 5'b00100,
        S_DEC  = 5'b01000,
        S_WB   = 5'b10000
    } seq_state_t;

    cfg_t cfg;

    mmkd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    seq_state_t         state_reg, state_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               raw_reg, raw_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic               oor_reg, oor_next;
    key_state_t         ks_reg, ks_next;
    logic [KEY_COUNT-1:0] valid_reg, valid_next;
    logic               use_hist_reg, use_hist_next;
    logic [FILL_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic [FILL_W-1:0]  got_cnt_reg, got_cnt_next;
    logic [PTR_W-1:0]   rpos_reg, rpos_next;
    logic               rv_reg, rv_next;
    logic [TIME_W-1:0]  prev_reg, prev_next;
    logic [TIME_W-1:0]  big_reg, big_next;
    logic               changed_reg, changed_next;
    logic               filtered_reg, filtered_next;
    logic [WAIT_W-1:0]  wait_reg, wait_next;

    logic               out_valid_reg, out_valid_next;
    logic               o_chg_reg, o_chg_next;
    logic               o_lvl_reg, o_lvl_next;
    logic               o_prs_reg, o_prs_next;
    logic               o_rel_reg, o_rel_next;
    logic               o_flt_reg, o_flt_next;
    logic [TIME_W-1:0]  o_cnt_reg, o_cnt_next;
    logic [TIME_W-1:0]  o_max_reg, o_max_next;
    logic [WAIT_W-1:0]  o_wait_reg, o_wait_next;

    logic [KA_W-1:0]    kaddr;
    logic [KA_W-1:0]    ks_raddr;
    logic [KS_W-1:0]    ks_rdata;
    logic               ks_we;
    logic [HA_W-1:0]    hist_base;
    logic [HA_W-1:0]    hist_waddr;
    logic [HA_W-1:0]    hist_raddr;
    logic               hist_we;
    logic [TIME_W-1:0]  hist_rdata;
    logic               in_fire;
    logic               out_load;

    always_comb
    begin
        logic [KX_W-1:0] in_kx;
        logic [KX_W-1:0] kx;
        in_kx    = KX_W'(sample_in.key_index);
        kx       = KX_W'(key_reg);
        ks_raddr = (state_reg == S_IDLE) ? in_kx[KA_W-1:0] : kx[KA_W-1:0];
        kaddr    = kx[KA_W-1:0];
    end

    assign hist_base  = HA_W'(HISTORY_DEPTH) * HA_W'(kaddr);
    assign hist_raddr = hist_base + HA_W'(rpos_reg);
    assign in_fire    = sample_in.valid && sample_in.ready;
    assign out_load   = (state_reg == S_WB) && (!out_valid_reg || result_out.ready);
    assign ks_we      = out_load && !oor_reg;

    mmkd_ram #(.WIDTH(KS_W), .DEPTH(KEY_COUNT)) u_state_ram (
        .clk   (clk),
        .we    (ks_we),
        .waddr (kaddr),
        .wdata (KS_W'(ks_reg)),
        .raddr (ks_raddr),
        .rdata (ks_rdata)
    );

    mmkd_ram #(.WIDTH(TIME_W), .DEPTH(HIST_ENTRIES)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (now_reg),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    always_comb
    begin
        key_state_t         ks_in;
        key_state_t         ks_u;
        logic [POS_W-1:0]   start_pos;
        logic [TIME_W-1:0]  gap;
        logic [TIME_W-1:0]  held;
        logic [TIME_W+1:0]  scaled;
        logic [WAIT_W-1:0]  base;
        logic [WAIT_W-1:0]  wait_a;
        logic [WAIT_W-1:0]  wait_c;
        logic               differ;
        logic               chg;
        logic [SCNT_W-1:0]  cnt1;

        state_next     = state_reg;
        key_next       = key_reg;
        raw_next       = raw_reg;
        now_next       = now_reg;
        oor_next       = oor_reg;
        ks_next        = ks_reg;
        valid_next     = valid_reg;
        use_hist_next  = use_hist_reg;
        issue_cnt_next = issue_cnt_reg;
        got_cnt_next   = got_cnt_reg;
        rpos_next      = rpos_reg;
        rv_next        = 1'b0;
        prev_next      = prev_reg;
        big_next       = big_reg;
        changed_next   = changed_reg;
        filtered_next  = filtered_reg;
        wait_next      = wait_reg;
        hist_we        = 1'b0;
        hist_waddr     = hist_base + HA_W'(ks_reg.wptr);

        ks_in     = valid_reg[kaddr] ? key_state_t'(ks_rdata) : '0;
        ks_u      = ks_in;
        start_pos = '0;
        gap       = hist_rdata - prev_reg;
        held      = now_reg - ks_reg.last_change;
        scaled    = ({2'b00, big_reg} + {1'b0, big_reg, 1'b0}) >> 1;
        base      = '0;
        wait_a    = '0;
        wait_c    = '0;
        differ    = 1'b0;
        chg       = 1'b0;
        cnt1      = ks_reg.sample_cnt + SCNT_W'(1);

        out_valid_next = out_valid_reg;
        if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        o_chg_next  = o_chg_reg;
        o_lvl_next  = o_lvl_reg;
        o_prs_next  = o_prs_reg;
        o_rel_next  = o_rel_reg;
        o_flt_next  = o_flt_reg;
        o_cnt_next  = o_cnt_reg;
        o_max_next  = o_max_reg;
        o_wait_next = o_wait_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    key_next   = sample_in.key_index;
                    raw_next   = sample_in.raw_level;
                    now_next   = sample_in.time_ms;
                    oor_next   = (32'(sample_in.key_index) >= KEY_COUNT);
                    state_next = oor_next ? S_WB : S_UPD;
                end
            end
            S_UPD:
            begin
                if (raw_reg != ks_in.last_raw)
                begin
                    ks_u.last_raw    = raw_reg;
                    ks_u.last_change = now_reg;
                    ks_u.change_cnt  = ks_in.change_cnt + 32'd1;
                    if (cfg.history_enable)
                    begin
                        hist_we    = 1'b1;
                        hist_waddr = hist_base + HA_W'(ks_in.wptr);
                        ks_u.wptr  = (ks_in.wptr == PTR_W'(HISTORY_DEPTH - 1)) ?
                                     '0 : ks_in.wptr + PTR_W'(1);
                        if (ks_in.fill < FILL_W'(HISTORY_DEPTH))
                        begin
                            ks_u.fill = ks_in.fill + FILL_W'(1);
                        end
                    end
                end
                ks_next   = ks_u;
                // Oldest logged entry: write pointer minus fill, modulo the depth.
                start_pos = POS_W'(ks_u.wptr) + POS_W'(HISTORY_DEPTH) - POS_W'(ks_u.fill);
                if (start_pos >= POS_W'(HISTORY_DEPTH))
                begin
                    start_pos = start_pos - POS_W'(HISTORY_DEPTH);
                end
                use_hist_next  = (ks_u.fill >= FILL_W'(MIN_FILL));
                issue_cnt_next = '0;
                got_cnt_next   = '0;
                rpos_next      = start_pos[PTR_W-1:0];
                big_next       = '0;
                if (cfg.method == M_ADAPT && use_hist_next)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DEC;
                end
            end
            S_SCAN:
            begin
                if (issue_cnt_reg < ks_reg.fill)
                begin
                    rv_next        = 1'b1;
                    issue_cnt_next = issue_cnt_reg + FILL_W'(1);
                    rpos_next      = (rpos_reg == PTR_W'(HISTORY_DEPTH - 1)) ?
                                     '0 : rpos_reg + PTR_W'(1);
                end
                if (rv_reg)
                begin
                    if (got_cnt_reg != '0 && gap > big_reg)
                    begin
                        big_next = gap;
                    end
                    prev_next    = hist_rdata;
                    got_cnt_next = got_cnt_reg + FILL_W'(1);
                    if (got_cnt_reg == ks_reg.fill - FILL_W'(1))
                    begin
                        state_next = S_DEC;
                    end
                end
            end
            S_DEC:
            begin
                base = use_hist_reg ?
                       ((scaled[TIME_W:WAIT_W] != '0) ? {WAIT_W{1'b1}} : scaled[WAIT_W-1:0]) :
                       cfg.delay_ms;
                wait_c = (base < cfg.adaptive_min_ms) ? cfg.adaptive_min_ms : base;
                wait_a = (wait_c > cfg.adaptive_max_ms) ? cfg.adaptive_max_ms : wait_c;
                differ = (raw_reg != ks_reg.debounced);
                filtered_next = 1'b0;
                wait_next     = cfg.delay_ms;
                case (cfg.method)
                    M_INTEG:
                    begin
                        if (differ)
                        begin
                            ks_next.sample_cnt = cnt1;
                            chg = (cnt1 >= SCNT_W'(cfg.sample_count));
                        end
                        else
                        begin
                            ks_next.sample_cnt = '0;
                        end
                    end
                    M_LOCK:
                    begin
                        if (!(now_reg < ks_reg.lock_until) && differ &&
                            held >= TIME_W'(cfg.delay_ms))
                        begin
                            chg = 1'b1;
                            ks_next.lock_until = now_reg + TIME_W'(cfg.delay_ms);
                        end
                    end
                    default:
                    begin
                        if (cfg.method == M_ADAPT)
                        begin
                            wait_next = wait_a;
                        end
                        if (differ)
                        begin
                            if (held >= TIME_W'(wait_next))
                            begin
                                chg = 1'b1;
                                if (cfg.method == M_ADAPT && held > ks_reg.longest)
                                begin
                                    ks_next.longest = held;
                                end
                            end
                            else
                            begin
                                filtered_next = 1'b1;
                            end
                        end
                        else
                        begin
                            ks_next.sample_cnt = cnt1;
                        end
                    end
                endcase
                if (chg)
                begin
                    ks_next.debounced  = raw_reg;
                    ks_next.sample_cnt = '0;
                end
                changed_next = chg;
                state_next   = S_WB;
            end
            S_WB:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    o_chg_next  = !oor_reg && changed_reg;
                    o_lvl_next  = !oor_reg && ks_reg.debounced;
                    o_prs_next  = !oor_reg && changed_reg && raw_reg;
                    o_rel_next  = !oor_reg && changed_reg && !raw_reg;
                    o_flt_next  = !oor_reg && filtered_reg;
                    o_cnt_next  = oor_reg ? '0 : ks_reg.change_cnt;
                    o_max_next  = oor_reg ? '0 : ks_reg.longest;
                    o_wait_next = oor_reg ? '0 : wait_reg;
                    if (!oor_reg)
                    begin
                        valid_next[kaddr] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            rv_reg        <= 1'b0;
            oor_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            rv_reg        <= rv_next;
            oor_reg       <= oor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        raw_reg       <= raw_next;
        now_reg       <= now_next;
        ks_reg        <= ks_next;
        use_hist_reg  <= use_hist_next;
        issue_cnt_reg <= issue_cnt_next;
        got_cnt_reg   <= got_cnt_next;
        rpos_reg      <= rpos_next;
        prev_reg      <= prev_next;
        big_reg       <= big_next;
        changed_reg   <= changed_next;
        filtered_reg  <= filtered_next;
        wait_reg      <= wait_next;
        o_chg_reg     <= o_chg_next;
        o_lvl_reg     <= o_lvl_next;
        o_prs_reg     <= o_prs_next;
        o_rel_reg     <= o_rel_next;
        o_flt_reg     <= o_flt_next;
        o_cnt_reg     <= o_cnt_next;
        o_max_reg     <= o_max_next;
        o_wait_reg    <= o_wait_next;
    end

    assign sample_in.ready             = (state_reg == S_IDLE);
    assign result_out.valid            = out_valid_reg;
    assign result_out.confirmed_change = o_chg_reg;
    assign result_out.stable_level     = o_lvl_reg;
    assign result_out.pressed_edge     = o_prs_reg;
    assign result_out.released_edge    = o_rel_reg;
    assign result_out.bounce_filtered  = o_flt_reg;
    assign result_out.raw_change_count = o_cnt_reg;
    assign result_out.max_bounce_ms    = o_max_reg;
    assign result_out.wait_used_ms     = o_wait_reg;

    `MMKD_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_reg != S_IDLE, "item accepted but sequencer stayed idle")
    `MMKD_ASSERT_NOW(a_edge_consistent, result_out.valid, result_out.confirmed_change == (result_out.pressed_edge | result_out.released_edge), "confirmed change disagrees with edges")
    `MMKD_ASSERT_NOW(a_press_level, result_out.valid && result_out.pressed_edge, result_out.stable_level, "pressed edge without pressed level")
    `MMKD_ASSERT_NOW(a_scan_bound, state_reg == S_SCAN, got_cnt_reg < ks_reg.fill, "history scan ran past the fill count")

endmodule

FILE: rtl/mmkd_ram.sv
`timescale 1ns / 1ps
module mmkd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/mmkd_cfg.sv
`timescale 1ns / 1ps
module mmkd_cfg import mmkd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_METHOD:  cfg_next.method          = method_t'(cfg_wdata[1:0]);
                REG_DELAY:   cfg_next.delay_ms        = cfg_wdata;
                REG_SAMPLES: cfg_next.sample_count    = cfg_wdata[SCFG_W-1:0];
                REG_MIN:     cfg_next.adaptive_min_ms = cfg_wdata;
                REG_MAX:     cfg_next.adaptive_max_ms = cfg_wdata;
                REG_HIST:    cfg_next.history_enable  = cfg_wdata[0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.method          <= M_DELAY;
            cfg_reg.delay_ms        <= 16'd20;
            cfg_reg.sample_count    <= 5'd5;
            cfg_reg.adaptive_min_ms <= 16'd5;
            cfg_reg.adaptive_max_ms <= 16'd100;
            cfg_reg.history_enable  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
